@@ src/mwf_pkg.sv @@
// shared types and constants of the right-hand wall follower
// request, cell, heading, status and register codes, and the ctrl/datapath structs
// no dependencies
`default_nettype none

package mwf_pkg;

   // field widths
   localparam int COORD_W     = 4;
   localparam int HEAD_W      = 2;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int REQ_TYPE_W  = 2;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 16;
   localparam int RSP_PAD_W   = RSP_DATA_W - 2 * COORD_W - HEAD_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 4;

   // neighbour slots, in order of preference
   localparam int NUM_SLOTS = 4;
   localparam int SLOT_W    = 2;
   localparam logic [SLOT_W-1:0] SLOT_RIGHT    = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_STRAIGHT = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_LEFT     = 2'd2;
   localparam logic [SLOT_W-1:0] SLOT_BACK     = 2'd3;

   // request types
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_RESTART = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_STEP    = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_NOP     = 2'd3;

   // cell kinds
   localparam logic [KIND_W-1:0] KIND_OPEN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WALL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SEEN = 2'd2;

   // headings
   localparam logic [HEAD_W-1:0] DIR_UP    = 2'd0;
   localparam logic [HEAD_W-1:0] DIR_RIGHT = 2'd1;
   localparam logic [HEAD_W-1:0] DIR_DOWN  = 2'd2;
   localparam logic [HEAD_W-1:0] DIR_LEFT  = 2'd3;

   // result status
   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MOVED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EXIT     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_STUCK    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ROW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_COL  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_HEAD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_ROW   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_COL   = 3'd4;

   // how the datapath finishes a request and loads the response
   typedef enum logic [2:0] {
      FIN_NONE,
      FIN_WRITE,
      FIN_RESTART,
      FIN_STEP,
      FIN_PLAIN
   } fin_op_type;

   typedef struct packed {
      logic              clr_step;
      logic              ld_req;
      logic              rd_start;
      logic              rd_nbr;
      logic [SLOT_W-1:0] rd_slot;
      logic              cap_en;
      logic [SLOT_W-1:0] cap_slot;
      fin_op_type        fin;
   } mwf_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic rsp_free;
      logic walk_active;
      logic walk_finished;
   } mwf_sts_type;

endpackage

`default_nettype wire

@@ src/mwf_ctrl.sv @@
// sequencer of the wall follower: clearing pass, request decode, neighbour reads
// depends on mwf_pkg
`default_nettype none

module mwf_ctrl
   import mwf_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   input  wire  [REQ_TYPE_W-1:0] req_tuser,
   output logic                  req_tready,
   input  mwf_sts_type           sts,
   output mwf_cmd_type           cmd
);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_WRITE   = 3'd2;
   localparam logic [2:0] S_RST_RD  = 3'd3;
   localparam logic [2:0] S_RST_DO  = 3'd4;
   localparam logic [2:0] S_STEP_RD = 3'd5;
   localparam logic [2:0] S_STEP_DO = 3'd6;
   localparam logic [2:0] S_PLAIN   = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      cmd.clr_step = 1'b0;
      cmd.ld_req   = 1'b0;
      cmd.rd_start = 1'b0;
      cmd.rd_nbr   = 1'b0;
      cmd.rd_slot  = slot_ff;
      cmd.cap_en   = 1'b0;
      cmd.cap_slot = SLOT_W'(slot_ff - 1'b1);
      cmd.fin      = FIN_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.ld_req = 1'b1;
               unique case (req_tuser)
                  REQ_WRITE:   state_in = S_WRITE;
                  REQ_RESTART: state_in = S_RST_RD;
                  REQ_STEP: begin
                     if (sts.walk_active && !sts.walk_finished) begin
                        state_in = S_STEP_RD;
                        slot_in  = SLOT_RIGHT;
                     end else begin
                        state_in = S_PLAIN;
                     end
                  end
                  REQ_NOP:     state_in = S_PLAIN;
               endcase
            end
         end
         S_WRITE: begin
            if (sts.rsp_free) begin
               cmd.fin  = FIN_WRITE;
               state_in = S_IDLE;
            end
         end
         S_RST_RD: begin
            cmd.rd_start = 1'b1;
            state_in     = S_RST_DO;
         end
         S_RST_DO: begin
            if (sts.rsp_free) begin
               cmd.fin  = FIN_RESTART;
               state_in = S_IDLE;
            end
         end
         S_STEP_RD: begin
            // read this slot, capture the one read in the cycle before
            cmd.rd_nbr = 1'b1;
            cmd.cap_en = (slot_ff != SLOT_RIGHT);
            slot_in    = SLOT_W'(slot_ff + 1'b1);
            if (slot_ff == SLOT_BACK) begin
               state_in = S_STEP_DO;
            end
         end
         S_STEP_DO: begin
            if (sts.rsp_free) begin
               cmd.fin  = FIN_STEP;
               state_in = S_IDLE;
            end
         end
         S_PLAIN: begin
            if (sts.rsp_free) begin
               cmd.fin  = FIN_PLAIN;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         slot_ff  <= SLOT_RIGHT;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end

`ifndef NO_ASSERTIONS
   // the decision is only reached after all four neighbour reads
   a_step_reads_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP_DO && $past(state_ff) != S_STEP_DO) |->
      ($past(state_ff) == S_STEP_RD && $past(slot_ff) == SLOT_BACK))
      else $error("decision entered before all neighbours were read");

   // the clearing pass is only ever entered from reset
   a_clear_from_reset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && !$past(reset)) |-> $past(state_ff) == S_CLEAR)
      else $error("clearing pass re-entered outside reset");
`endif

endmodule

`default_nettype wire

@@ src/mwf_datapath.sv @@
// datapath of the wall follower: grid memory, walker registers, neighbour
// lanes, move choice, config registers and response register
// depends on mwf_pkg
`default_nettype none

module mwf_datapath
   import mwf_pkg::*;
#(
   parameter int ROWS = 16,
   parameter int COLS = 16
)
(
   input  wire                    clock,
   input  wire                    reset,
   input  mwf_cmd_type            cmd,
   output mwf_sts_type            sts,
   input  wire  [REQ_DATA_W-1:0]  req_tdata,
   input  wire  [REQ_TYPE_W-1:0]  req_tuser,
   input  wire                    csr_we,
   input  wire  [CSR_INDEX_W-1:0] csr_index,
   input  wire  [CSR_DATA_W-1:0]  csr_data,
   input  wire                    rsp_tready,
   output logic                   rsp_tvalid,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic [STATUS_W-1:0]    rsp_tuser
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = COORD_W + 1;

   // heading offset of each slot: right, straight, left, back
   localparam logic [HEAD_W-1:0] SLOT_TURN [NUM_SLOTS] = '{2'd1, 2'd0, 2'd3, 2'd2};

   function automatic logic in_grid(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                    input logic [COORD_W-1:0] lr,
                                    input logic [COORD_W-1:0] lc);
      return (r <= {1'b0, lr}) && (c <= {1'b0, lc}) &&
             (32'(r) < ROWS) && (32'(c) < COLS);
   endfunction

   function automatic logic on_border(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                      input logic [COORD_W-1:0] lr,
                                      input logic [COORD_W-1:0] lc);
      return (r == '0) || (c == '0) || (r == {1'b0, lr}) || (c == {1'b0, lc});
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                               input logic [CW-1:0] c);
      int a;
      a = int'(r) * COLS + int'(c);
      return AW'(a);
   endfunction

   // config registers
   logic [COORD_W-1:0] start_row_ff, start_col_ff, last_row_ff, last_col_ff;
   logic [HEAD_W-1:0]  start_head_ff;

   // walker state
   logic [COORD_W-1:0] walk_row_ff, walk_row_in, walk_col_ff, walk_col_in;
   logic [HEAD_W-1:0]  walk_head_ff, walk_head_in;
   logic               walk_active_ff, walk_active_in;
   logic               walk_finished_ff, walk_finished_in;

   // latched request
   logic [REQ_TYPE_W-1:0] req_type_ff;
   logic [COORD_W-1:0]    req_row_ff, req_col_ff;
   logic [KIND_W-1:0]     req_kind_ff;

   // grid memory
   logic [KIND_W-1:0] grid_ff [DEPTH];
   logic [KIND_W-1:0] grid_q_ff;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [KIND_W-1:0] mem_wdata;
   logic [AW-1:0]     clr_cnt_ff;

   // neighbour lanes
   logic [HEAD_W-1:0] nb_dir  [NUM_SLOTS];
   logic              nb_edge [NUM_SLOTS];
   logic [CW-1:0]     nb_row  [NUM_SLOTS];
   logic [CW-1:0]     nb_col  [NUM_SLOTS];
   logic              nb_ok   [NUM_SLOTS];
   logic [AW-1:0]     nb_addr [NUM_SLOTS];
   logic [KIND_W-1:0] kind_ff   [NUM_SLOTS-1];
   logic [KIND_W-1:0] slot_raw  [NUM_SLOTS];
   logic [KIND_W-1:0] slot_kind [NUM_SLOTS];
   logic              pick_found;
   logic [SLOT_W-1:0] pick_slot;

   // start cell and write target
   logic              st_ok;
   logic [AW-1:0]     st_addr;
   logic [KIND_W-1:0] st_kind;
   logic              st_border;
   logic              req_in_store;
   logic [AW-1:0]     req_addr;
   logic [KIND_W-1:0] req_kind_fix;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]    rsp_row_ff, rsp_col_ff;
   logic [HEAD_W-1:0]     rsp_head_ff;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_load;

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         nb_dir[i]  = HEAD_W'(walk_head_ff + SLOT_TURN[i]);
         nb_edge[i] = 1'b0;
         nb_row[i]  = {1'b0, walk_row_ff};
         nb_col[i]  = {1'b0, walk_col_ff};
         unique case (nb_dir[i])
            DIR_UP: begin
               nb_edge[i] = (walk_row_ff == '0);
               nb_row[i]  = CW'({1'b0, walk_row_ff} - 1'b1);
            end
            DIR_RIGHT: begin
               nb_col[i] = CW'({1'b0, walk_col_ff} + 1'b1);
            end
            DIR_DOWN: begin
               nb_row[i] = CW'({1'b0, walk_row_ff} + 1'b1);
            end
            DIR_LEFT: begin
               nb_edge[i] = (walk_col_ff == '0);
               nb_col[i]  = CW'({1'b0, walk_col_ff} - 1'b1);
            end
         endcase
         nb_ok[i]   = !nb_edge[i] && in_grid(nb_row[i], nb_col[i], last_row_ff, last_col_ff);
         nb_addr[i] = cell_addr(nb_row[i], nb_col[i]);
      end
   end

   // slot kinds: the back slot comes straight off the memory output
   always_comb begin
      for (int i = 0; i < NUM_SLOTS - 1; i++) begin
         slot_raw[i] = kind_ff[i];
      end
      slot_raw[NUM_SLOTS-1] = grid_q_ff;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_kind[i] = nb_ok[i] ? slot_raw[i] : KIND_WALL;
      end
   end

   // first open unvisited neighbour, else first visited one
   always_comb begin
      pick_found = 1'b0;
      pick_slot  = SLOT_RIGHT;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (!pick_found && slot_kind[i] == KIND_OPEN) begin
            pick_found = 1'b1;
            pick_slot  = SLOT_W'(i);
         end
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (!pick_found && slot_kind[i] == KIND_SEEN) begin
            pick_found = 1'b1;
            pick_slot  = SLOT_W'(i);
         end
      end
   end

   assign st_ok     = in_grid({1'b0, start_row_ff}, {1'b0, start_col_ff},
                              last_row_ff, last_col_ff);
   assign st_addr   = cell_addr({1'b0, start_row_ff}, {1'b0, start_col_ff});
   assign st_kind   = st_ok ? grid_q_ff : KIND_WALL;
   assign st_border = on_border({1'b0, start_row_ff}, {1'b0, start_col_ff},
                                last_row_ff, last_col_ff);

   assign req_in_store = (32'(req_row_ff) < ROWS) && (32'(req_col_ff) < COLS);
   assign req_addr     = cell_addr({1'b0, req_row_ff}, {1'b0, req_col_ff});
   assign req_kind_fix = (req_kind_ff == KIND_OPEN || req_kind_ff == KIND_SEEN) ?
                         req_kind_ff : KIND_WALL;

   // memory ports
   assign mem_re    = cmd.rd_start || cmd.rd_nbr;
   assign mem_raddr = cmd.rd_start ? st_addr : nb_addr[cmd.rd_slot];

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_cnt_ff;
      mem_wdata = KIND_WALL;
      if (cmd.clr_step) begin
         mem_we = 1'b1;
      end else begin
         unique case (cmd.fin)
            FIN_WRITE: begin
               mem_we    = req_in_store;
               mem_waddr = req_addr;
               mem_wdata = req_kind_fix;
            end
            FIN_RESTART: begin
               mem_we    = (st_kind == KIND_OPEN);
               mem_waddr = st_addr;
               mem_wdata = KIND_SEEN;
            end
            FIN_STEP: begin
               mem_we    = pick_found;
               mem_waddr = nb_addr[pick_slot];
               mem_wdata = KIND_SEEN;
            end
            default: begin
               mem_we = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         grid_q_ff <= grid_ff[mem_raddr];
      end
   end

   // walker update and response status
   always_comb begin
      walk_row_in      = walk_row_ff;
      walk_col_in      = walk_col_ff;
      walk_head_in     = walk_head_ff;
      walk_active_in   = walk_active_ff;
      walk_finished_in = walk_finished_ff;
      rsp_status_in    = ST_ACCEPTED;
      unique case (cmd.fin)
         FIN_RESTART: begin
            walk_row_in      = start_row_ff;
            walk_col_in      = start_col_ff;
            walk_head_in     = start_head_ff;
            walk_active_in   = 1'b1;
            walk_finished_in = (st_kind == KIND_SEEN) && st_border;
            rsp_status_in    = walk_finished_in ? ST_EXIT : ST_ACCEPTED;
         end
         FIN_STEP: begin
            if (pick_found) begin
               walk_row_in      = nb_row[pick_slot][COORD_W-1:0];
               walk_col_in      = nb_col[pick_slot][COORD_W-1:0];
               walk_head_in     = nb_dir[pick_slot];
               walk_finished_in = on_border(nb_row[pick_slot], nb_col[pick_slot],
                                            last_row_ff, last_col_ff);
               rsp_status_in    = walk_finished_in ? ST_EXIT : ST_MOVED;
            end else begin
               rsp_status_in = ST_STUCK;
            end
         end
         FIN_PLAIN: begin
            if (req_type_ff == REQ_STEP) begin
               rsp_status_in = walk_active_ff ? ST_FINISHED : ST_STUCK;
            end
         end
         default: begin
            rsp_status_in = ST_ACCEPTED;
         end
      endcase
   end

   assign rsp_load     = (cmd.fin != FIN_NONE);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_row_ff     <= '0;
         start_col_ff     <= '0;
         start_head_ff    <= DIR_RIGHT;
         last_row_ff      <= '1;
         last_col_ff      <= '1;
         walk_row_ff      <= '0;
         walk_col_ff      <= '0;
         walk_head_ff     <= DIR_RIGHT;
         walk_active_ff   <= 1'b0;
         walk_finished_ff <= 1'b0;
         clr_cnt_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_START_ROW:  start_row_ff  <= csr_data;
               CSR_START_COL:  start_col_ff  <= csr_data;
               CSR_START_HEAD: start_head_ff <= csr_data[HEAD_W-1:0];
               CSR_LAST_ROW:   last_row_ff   <= csr_data;
               CSR_LAST_COL:   last_col_ff   <= csr_data;
               default: begin
               end
            endcase
         end
         walk_row_ff      <= walk_row_in;
         walk_col_ff      <= walk_col_in;
         walk_head_ff     <= walk_head_in;
         walk_active_ff   <= walk_active_in;
         walk_finished_ff <= walk_finished_in;
         if (cmd.clr_step) begin
            clr_cnt_ff <= AW'(clr_cnt_ff + 1'b1);
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         req_type_ff <= req_tuser;
         req_row_ff  <= req_tdata[COORD_W-1:0];
         req_col_ff  <= req_tdata[2*COORD_W-1:COORD_W];
         req_kind_ff <= req_tdata[2*COORD_W+KIND_W-1:2*COORD_W];
      end
      if (cmd.cap_en) begin
         kind_ff[cmd.cap_slot] <= grid_q_ff;
      end
      if (rsp_load) begin
         rsp_row_ff    <= walk_row_in;
         rsp_col_ff    <= walk_col_in;
         rsp_head_ff   <= walk_head_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_head_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_status_ff;

   assign sts.clr_done      = (clr_cnt_ff == AW'(DEPTH - 1));
   assign sts.rsp_free      = !rsp_valid_ff || rsp_tready;
   assign sts.walk_active   = walk_active_ff;
   assign sts.walk_finished = walk_finished_ff;

`ifndef NO_ASSERTIONS
   // a held response is never overwritten
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> cmd.fin == FIN_NONE)
      else $error("response register overwritten while stalled");

   // a finished walk is always an active one
   a_finished_active: assert property (@(posedge clock) disable iff (reset)
      walk_finished_ff |-> walk_active_ff)
      else $error("walk finished without being active");

   // a move decision only happens on a live walk
   a_step_live: assert property (@(posedge clock) disable iff (reset)
      (cmd.fin == FIN_STEP) |-> (walk_active_ff && !walk_finished_ff))
      else $error("step decided on a walk that is not live");
`endif

endmodule

`default_nettype wire

@@ src/maze_wall_follower_step.sv @@
// Right-hand wall follower on a grid maze, one request at a time.
//
// req channel: one request per handshake. req_tuser selects write cell,
//   restart walker, step, or no operation. A write stores one cell as open,
//   wall or visited; a restart puts the walker at the configured start cell
//   and heading; a step tries right, straight, left, back, open cells first,
//   then visited ones, and moves one cell.
// rsp channel: exactly one response per request: walker row, column and
//   heading after the request, with a status (accepted, moved, exit, stuck,
//   already finished) in rsp_tuser.
// csr channel: always ready; registers are to be written between requests, which the
//   block itself does not enforce. Request accept to response load: write, no-op and
//   refused steps pass one finishing state, restart reads the start cell first, step
//   does four neighbour reads through the single read port of the grid memory, then
//   decides. The next request is taken in the cycle after the response is loaded.
// Reset: the grid memory is swept to wall, one cell a cycle over all ROWS*COLS cells,
//   with req_tready low; csr writes are taken during the sweep.
// Stall: the response sits in an output register; a new request is still
//   accepted and worked on, and only its response load waits for rsp_tready.
// depends on mwf_pkg, mwf_ctrl, mwf_datapath
`default_nettype none

module maze_wall_follower_step
   import mwf_pkg::*;
#(
   parameter int ROWS = 16,   // rows of grid storage
   parameter int COLS = 16    // columns of grid storage
)
(
   input  wire                    clock,
   input  wire                    reset,
   // request channel
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [REQ_DATA_W-1:0]  req_tdata,   // cell_row[3:0], cell_col[7:4], cell_kind[9:8]
   input  wire  [REQ_TYPE_W-1:0]  req_tuser,   // req_type[1:0]
   // response channel
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // pos_row[3:0], pos_col[7:4], heading[9:8]
   output logic [STATUS_W-1:0]    rsp_tuser,   // status[2:0]
   // register write channel
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [CSR_INDEX_W-1:0] csr_index,
   input  wire  [CSR_DATA_W-1:0]  csr_data
);

   mwf_cmd_type cmd;
   mwf_sts_type sts;

   // register writes never stall
   assign csr_ready = 1'b1;

   // sequencer: clearing pass, decode, neighbour read schedule
   mwf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // grid memory, walker state and response register
   mwf_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ bench/tb_maze_wall_follower_step.sv @@
// self-checking bench for the right-hand wall follower: directed table, then random mazes
// walked under several pacing modes, each response checked against a walker model or a pinned value
// depends on mwf_pkg and maze_wall_follower_step
`timescale 1ns / 1ps

module tb_maze_wall_follower_step;
   import mwf_pkg::*;

   localparam int GRID_ROWS   = 16;
   localparam int GRID_COLS   = 16;
   localparam int PHASE_ITEMS = 160;
   localparam int PROBE_ROWS  = 22;
   localparam int PROBE_SPLIT = 12;   // start/grid registers change before this row
   localparam int MAX_REPORTS = 40;

   // spare kind code, stored as a wall
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] op;
      logic [COORD_W-1:0]    row;
      logic [COORD_W-1:0]    col;
      logic [KIND_W-1:0]     kind;
   } maze_req_type;

   typedef struct packed {
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic [HEAD_W-1:0]   head;
      logic [STATUS_W-1:0] status;
   } walk_rsp_type;

   typedef struct packed {
      maze_req_type rq;
      logic         pinned;   // response written out below instead of predicted
      walk_rsp_type want;
   } probe_row_type;

   // clock, reset and block ports
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [REQ_TYPE_W-1:0]  req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // walker model state, mirrors the block
   logic [KIND_W-1:0]  mz_cell [0:GRID_ROWS*GRID_COLS-1];
   int                 mz_row;
   int                 mz_col;
   logic [HEAD_W-1:0]  mz_head;
   logic               mz_active;
   logic               mz_done;

   // model copy of the registers
   logic [COORD_W-1:0] cf_start_row;
   logic [COORD_W-1:0] cf_start_col;
   logic [HEAD_W-1:0]  cf_start_head;
   logic [COORD_W-1:0] cf_last_row;
   logic [COORD_W-1:0] cf_last_col;

   walk_rsp_type expected_walk_q [$];

   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int err_count      = 0;
   int n_req          = 0;
   int n_rsp          = 0;
   int n_moves        = 0;
   int n_exits        = 0;
   int n_stuck        = 0;
   int n_after_exit   = 0;

   // directed requests: before any restart, no-op, spare kind, restart on a wall,
   // stuck in a solid grid, exit at once, step after exit, restart on a visited
   // border cell, then an inner walk with visited fallback in a 10x10 grid
   probe_row_type probe_tab [0:PROBE_ROWS-1] = '{
      '{'{REQ_STEP,    4'd0,  4'd0,  KIND_OPEN},  1'b1, '{4'd0, 4'd0, DIR_RIGHT, ST_STUCK}},
      '{'{REQ_NOP,     4'd15, 4'd15, KIND_SPARE}, 1'b1, '{4'd0, 4'd0, DIR_RIGHT, ST_ACCEPTED}},
      '{'{REQ_WRITE,   4'd15, 4'd15, KIND_SPARE}, 1'b1, '{4'd0, 4'd0, DIR_RIGHT, ST_ACCEPTED}},
      '{'{REQ_RESTART, 4'd0,  4'd0,  KIND_OPEN},  1'b1, '{4'd0, 4'd0, DIR_RIGHT, ST_ACCEPTED}},
      '{'{REQ_STEP,    4'd0,  4'd0,  KIND_OPEN},  1'b1, '{4'd0, 4'd0, DIR_RIGHT, ST_STUCK}},
      '{'{REQ_WRITE,   4'd0,  4'd0,  KIND_OPEN},  1'b0, '0},
      '{'{REQ_WRITE,   4'd1,  4'd0,  KIND_OPEN},  1'b0, '0},
      '{'{REQ_WRITE,   4'd0,  4'd1,  KIND_SEEN},  1'b0, '0},
      '{'{REQ_RESTART, 4'd9,  4'd3,  KIND_WALL},  1'b0, '0},
      '{'{REQ_STEP,    4'd0,  4'd0,  KIND_OPEN},  1'b0, '0},
      '{'{REQ_STEP,    4'd0,  4'd0,  KIND_OPEN},  1'b1, '{4'd1, 4'd0, DIR_DOWN,  ST_FINISHED}},
      '{'{REQ_RESTART, 4'd0,  4'd0,  KIND_OPEN},  1'b1, '{4'd0, 4'd0, DIR_RIGHT, ST_EXIT}},
      '{'{REQ_WRITE,   4'd5,  4'd5,  KIND_OPEN},  1'b0, '0},
      '{'{REQ_WRITE,   4'd5,  4'd6,  KIND_OPEN},  1'b0, '0},
      '{'{REQ_WRITE,   4'd4,  4'd5,  KIND_SEEN},  1'b0, '0},
      '{'{REQ_RESTART, 4'd0,  4'd0,  KIND_OPEN},  1'b0, '0},
      '{'{REQ_STEP,    4'd0,  4'd0,  KIND_OPEN},  1'b0, '0},
      '{'{REQ_STEP,    4'd0,  4'd0,  KIND_OPEN},  1'b0, '0},
      '{'{REQ_STEP,    4'd0,  4'd0,  KIND_OPEN},  1'b0, '0},
      '{'{REQ_WRITE,   4'd10, 4'd5,  KIND_OPEN},  1'b0, '0},
      '{'{REQ_STEP,    4'd0,  4'd0,  KIND_OPEN},  1'b0, '0},
      '{'{REQ_STEP,    4'd0,  4'd0,  KIND_OPEN},  1'b0, '0}
   };

   maze_wall_follower_step DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // cells off the active grid, or past row/column zero, read as wall
   function automatic logic [KIND_W-1:0] kind_at(int r, int c);
      if (r < 0 || c < 0 || r > int'(cf_last_row) || c > int'(cf_last_col) ||
          r >= GRID_ROWS || c >= GRID_COLS)
         return KIND_WALL;
      return mz_cell[r * GRID_COLS + c];
   endfunction

   function automatic logic at_border(int r, int c);
      return r == 0 || c == 0 || r == int'(cf_last_row) || c == int'(cf_last_col);
   endfunction

   // applies one accepted request to the walker model, returns the response it owes
   function automatic walk_rsp_type predict_walk(maze_req_type rq);
      walk_rsp_type      res;
      logic [KIND_W-1:0] k;
      logic              taken;
      int                d;
      int                nr;
      int                nc;
      res.status = ST_ACCEPTED;
      case (rq.op)
         REQ_WRITE: begin
            k = (rq.kind == KIND_SPARE) ? KIND_WALL : rq.kind;
            mz_cell[int'(rq.row) * GRID_COLS + int'(rq.col)] = k;
         end
         REQ_RESTART: begin
            k = kind_at(int'(cf_start_row), int'(cf_start_col));
            mz_row    = int'(cf_start_row);
            mz_col    = int'(cf_start_col);
            mz_head   = cf_start_head;
            mz_active = 1'b1;
            mz_done   = 1'b0;
            if (k == KIND_SEEN && at_border(mz_row, mz_col)) begin
               // start cell already walked on the border: exit straight away
               mz_done    = 1'b1;
               res.status = ST_EXIT;
            end else if (k == KIND_OPEN) begin
               mz_cell[mz_row * GRID_COLS + mz_col] = KIND_SEEN;
            end
         end
         REQ_STEP: begin
            if (!mz_active) begin
               res.status = ST_STUCK;
            end else if (mz_done) begin
               res.status = ST_FINISHED;
            end else begin
               res.status = ST_STUCK;
               taken = 1'b0;
               // right, straight, left, back: open cells first, then visited ones
               for (int i = 0; i < 8 && !taken; i++) begin
                  d  = (int'(mz_head) + 5 - (i % 4)) % 4;
                  nr = mz_row;
                  nc = mz_col;
                  case (d[HEAD_W-1:0])
                     DIR_UP:    nr = mz_row - 1;
                     DIR_RIGHT: nc = mz_col + 1;
                     DIR_DOWN:  nr = mz_row + 1;
                     default:   nc = mz_col - 1;
                  endcase
                  k = kind_at(nr, nc);
                  if ((i < 4 && k == KIND_OPEN) || (i >= 4 && k == KIND_SEEN)) begin
                     taken   = 1'b1;
                     mz_head = d[HEAD_W-1:0];
                     mz_row  = nr;
                     mz_col  = nc;
                     mz_cell[nr * GRID_COLS + nc] = KIND_SEEN;
                     if (at_border(nr, nc)) begin
                        mz_done    = 1'b1;
                        res.status = ST_EXIT;
                     end else begin
                        res.status = ST_MOVED;
                     end
                  end
               end
            end
         end
         default: ;   // no-op request
      endcase
      res.row  = mz_row[COORD_W-1:0];
      res.col  = mz_col[COORD_W-1:0];
      res.head = mz_head;
      return res;
   endfunction

   function automatic logic [COORD_W-1:0] clamp_to(int v, int hi);
      if (v < 0)
         return '0;
      if (v > hi)
         return hi[COORD_W-1:0];
      return v[COORD_W-1:0];
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 58)
         return KIND_OPEN;
      else if (roll < 90)
         return KIND_WALL;
      else if (roll < 97)
         return KIND_SEEN;
      return KIND_SPARE;
   endfunction

   // drives one request at the falling edge, holds it until taken, then logs what it owes
   task automatic send_req(input maze_req_type rq, input logic pinned,
                           input walk_rsp_type want, output walk_rsp_type pred);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = rq.op;
      req_tdata  = {6'd0, rq.kind, rq.col, rq.row};
      do @(posedge clock); while (!req_tready);
      pred = predict_walk(rq);
      expected_walk_q.push_back(pinned ? want : pred);
      n_req++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_walk_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_START_ROW:  cf_start_row  = val;
         CSR_START_COL:  cf_start_col  = val;
         CSR_START_HEAD: cf_start_head = val[HEAD_W-1:0];
         CSR_LAST_ROW:   cf_last_row   = val;
         CSR_LAST_COL:   cf_last_col   = val;
         default: ;
      endcase
   endtask

   task automatic load_config(input int sr, input int sc, input int sh,
                              input int lr, input int lc);
      write_csr(CSR_START_ROW,  sr[CSR_DATA_W-1:0]);
      write_csr(CSR_START_COL,  sc[CSR_DATA_W-1:0]);
      write_csr(CSR_START_HEAD, sh[CSR_DATA_W-1:0]);
      write_csr(CSR_LAST_ROW,   lr[CSR_DATA_W-1:0]);
      write_csr(CSR_LAST_COL,   lc[CSR_DATA_W-1:0]);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // any request type with any field bits
   task automatic send_noise();
      maze_req_type rq;
      walk_rsp_type pred;
      rq.op   = REQ_TYPE_W'($urandom_range(0, 3));
      rq.row  = COORD_W'($urandom_range(0, 15));
      rq.col  = COORD_W'($urandom_range(0, 15));
      rq.kind = KIND_W'($urandom_range(0, 3));
      send_req(rq, 1'b0, '0, pred);
   endtask

   // build a maze (whole grid when small, a patch round the start otherwise),
   // restart, then walk until exit or a step cap, stopping early at random when stuck
   task automatic run_episode();
      maze_req_type rq;
      walk_rsp_type pred;
      int           n_cols;
      int           n_cells;
      int           n_writes;
      n_cols   = int'(cf_last_col) + 1;
      n_cells  = (int'(cf_last_row) + 1) * n_cols;
      n_writes = (n_cells <= 64) ? n_cells : 64;
      for (int w = 0; w < n_writes; w++) begin
         if ($urandom_range(0, 19) == 0)
            send_noise();
         rq.op = REQ_WRITE;
         if (n_cells <= 64) begin
            rq.row = COORD_W'(w / n_cols);
            rq.col = COORD_W'(w % n_cols);
         end else begin
            rq.row = clamp_to(int'(cf_start_row) + int'($urandom_range(0, 8)) - 4,
                              int'(cf_last_row));
            rq.col = clamp_to(int'(cf_start_col) + int'($urandom_range(0, 8)) - 4,
                              int'(cf_last_col));
         end
         rq.kind = pick_kind();
         send_req(rq, 1'b0, '0, pred);
      end
      // mostly leave the start cell open so the walk gets going
      rq.row  = cf_start_row;
      rq.col  = cf_start_col;
      rq.kind = ($urandom_range(0, 99) < 85) ? KIND_OPEN : pick_kind();
      send_req(rq, 1'b0, '0, pred);
      if ($urandom_range(0, 7) == 0)
         wait_drained();
      rq.op   = REQ_RESTART;
      rq.row  = COORD_W'($urandom_range(0, 15));
      rq.col  = COORD_W'($urandom_range(0, 15));
      rq.kind = KIND_W'($urandom_range(0, 3));
      send_req(rq, 1'b0, '0, pred);
      rq.op = REQ_STEP;
      for (int s = 0; s < 60 && !mz_done; s++) begin
         if ($urandom_range(0, 24) == 0)
            send_noise();
         rq.row = COORD_W'($urandom_range(0, 15));
         rq.col = COORD_W'($urandom_range(0, 15));
         send_req(rq, 1'b0, '0, pred);
         if (pred.status == ST_STUCK && $urandom_range(0, 1) == 1)
            break;
      end
      if (mz_done && $urandom_range(0, 2) == 0)
         send_req(rq, 1'b0, '0, pred);
   endtask

   task automatic run_phase(input pace_type pace, input int sr, input int sc, input int sh,
                            input int lr, input int lc);
      int first;
      wait_drained();
      case (pace)
         PACE_SEND_GAPS:   begin send_gap_pct = 68; recv_stall_pct = 0;  end
         PACE_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 68; end
         PACE_BOTH:        begin send_gap_pct = 33; recv_stall_pct = 33; end
         default:          begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      endcase
      load_config(sr, sc, sh, lr, lc);
      first = n_req;
      while (n_req - first < PHASE_ITEMS)
         run_episode();
   endtask

   // receiver: stalls at random per cycle, changes only at the falling edge
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // response checker, sampled at the rising edge
   always @(posedge clock) begin : rsp_check
      walk_rsp_type got;
      walk_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.row    = rsp_tdata[3:0];
         got.col    = rsp_tdata[7:4];
         got.head   = rsp_tdata[9:8];
         got.status = rsp_tuser;
         if (expected_walk_q.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
               $display("%0t: response with none outstanding: row %0d col %0d head %0d st %0d",
                        $time, got.row, got.col, got.head, got.status);
         end else begin
            want = expected_walk_q.pop_front();
            n_rsp++;
            case (want.status)
               ST_MOVED:    n_moves++;
               ST_EXIT:     n_exits++;
               ST_STUCK:    n_stuck++;
               ST_FINISHED: n_after_exit++;
               default: ;
            endcase
            if (got !== want) begin
               err_count++;
               if (err_count <= MAX_REPORTS)
                  $display({"%0t: mismatch expected row %0d col %0d head %0d st %0d, ",
                            "got row %0d col %0d head %0d st %0d"},
                           $time, want.row, want.col, want.head, want.status,
                           got.row, got.col, got.head, got.status);
            end
         end
      end
   end

   // main sequence
   initial begin : stimulus
      walk_rsp_type pred;
      int           lr;
      int           lc;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_NOP;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_START_ROW;
      csr_data   = '0;
      foreach (mz_cell[i])
         mz_cell[i] = KIND_WALL;
      mz_row        = 0;
      mz_col        = 0;
      mz_head       = DIR_RIGHT;
      mz_active     = 1'b0;
      mz_done       = 1'b0;
      cf_start_row  = '0;
      cf_start_col  = '0;
      cf_start_head = DIR_RIGHT;
      cf_last_row   = 4'd15;
      cf_last_col   = 4'd15;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table, reset registers first, then a 10x10 grid from the middle
      for (int i = 0; i < PROBE_ROWS; i++) begin
         if (i == PROBE_SPLIT) begin
            wait_drained();
            load_config(5, 5, int'(DIR_UP), 9, 9);
         end
         send_req(probe_tab[i].rq, probe_tab[i].pinned, probe_tab[i].want, pred);
      end

      // random mazes: small and lopsided grids, the smallest and the full one,
      // starts in corners and off the grid, each pacing mode twice
      run_phase(PACE_FULL,        1,  1,  int'(DIR_RIGHT), 4,  4);
      run_phase(PACE_SEND_GAPS,   0,  0,  int'(DIR_UP),    1,  1);
      run_phase(PACE_RECV_STALLS, 15, 15, int'(DIR_LEFT),  15, 15);
      lr = $urandom_range(3, 7);
      lc = $urandom_range(3, 7);
      run_phase(PACE_BOTH, $urandom_range(0, lr), $urandom_range(0, lc),
                $urandom_range(0, 3), lr, lc);
      run_phase(PACE_FULL,        2,  7,  int'(DIR_DOWN),  3,  15);
      run_phase(PACE_SEND_GAPS,   12, 1,  $urandom_range(0, 3), 15, 2);
      run_phase(PACE_RECV_STALLS, $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom_range(0, 3), $urandom_range(1, 15), $urandom_range(1, 15));
      lr = $urandom_range(2, 5);
      lc = $urandom_range(2, 5);
      run_phase(PACE_BOTH, $urandom_range(0, lr), $urandom_range(0, lc),
                $urandom_range(0, 3), lr, lc);

      wait_drained();
      repeat (16) @(posedge clock);

      $display("covered %0d requests in ten register settings: %0d moves, %0d exits, %0d stuck",
               n_req, n_moves, n_exits, n_stuck);
      $display("%0d steps after exit, %0d responses checked under four pacing modes",
               n_after_exit, n_rsp);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // hard stop well past the slowest legal run, reset sweep included
   initial begin : watchdog
      #4_000_000;
      $display("%0t: run did not complete, %0d responses outstanding",
               $time, expected_walk_q.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ maze_wall_follower_step.f @@
src/mwf_pkg.sv
src/mwf_ctrl.sv
src/mwf_datapath.sv
src/maze_wall_follower_step.sv
bench/tb_maze_wall_follower_step.sv
